FILE: src/wpip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpip_pkg
// Shared codes and types of the winding point-in-polygon classifier.
// ----------------------------------------------------------------------------
package wpip_pkg;

    // item modes
    localparam logic [1:0] MODE_START    = 2'd0;
    localparam logic [1:0] MODE_APPEND   = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;

    // position classes
    localparam logic [1:0] CLASS_OUTSIDE = 2'd0;
    localparam logic [1:0] CLASS_INSIDE  = 2'd1;
    localparam logic [1:0] CLASS_EDGE    = 2'd2;
    localparam logic [1:0] CLASS_VERTEX  = 2'd3;

    // control states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

endpackage

FILE: src/winding_point_in_polygon_classifier.sv
// Loads are registered; a query on an empty or single-vertex polygon,
// or on the last stored vertex, answers in the cycle after the transfer.
// Other queries walk the vertex memory one entry per cycle through a four
// stage read/difference/multiply/accumulate pipe, ending early when a
// vertex or edge hit stops the walk; busy blocks new transfers.
// Synchronous active-low reset clears count, drop flag and control; no stall.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winding_point_in_polygon_classifier
// Stores polygon vertices in a one-write one-read memory and classifies query
// points as outside, inside (nonzero winding), on an edge or on a vertex.
// ----------------------------------------------------------------------------
module winding_point_in_polygon_classifier
    import wpip_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    output logic               o_strobe,
    output logic [1:0]         o_position_class,
    output logic               o_vertices_dropped
);

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW     = COORD_BITS + 1;
    localparam int PW     = 2 * DW;
    localparam int WW     = CNT_W + 1;

    // vertex memory, x in the upper half
    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] r_rd_data;

    // control state
    t_state                r_state,    n_state;
    logic [CNT_W-1:0]      r_count,    n_count;
    logic                  r_overflow, n_overflow;
    logic                  r_issuing,  n_issuing;
    logic [ADDR_W-1:0]     r_rd_addr,  n_rd_addr;
    logic                  r_v1,       n_v1;
    logic                  r_e2,       n_e2;
    logic                  r_e3,       n_e3;
    logic signed [WW-1:0]  r_wind,     n_wind;
    logic                  r_strobe,   n_strobe;
    logic [1:0]            r_class,    n_class;
    logic                  r_dropped,  n_dropped;

    // payload pipeline
    logic signed [COORD_BITS-1:0] r_px, r_py, r_last_x, r_last_y;
    logic                         r_first1, r_last1, r_last2, r_last3;
    logic signed [DW-1:0]         r_wx, r_wy, r_ux, r_uy;
    logic signed [PW-1:0]         r_p1, r_p2;
    logic                         r_hit, r_box, r_up, r_dn;

    logic                         accept;
    logic                         room;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            end_addr;
    logic signed [COORD_BITS-1:0] qx, qy, rd_x, rd_y;
    logic signed [DW-1:0]         dx, dy;
    logic signed [PW:0]           cross_prod;
    logic                         cross_zero, cross_pos, cross_neg;
    logic                         edge_stop, walk_done;
    logic signed [WW-1:0]         wind_step;
    logic                         ux_le, ux_ge, wx_le, wx_ge, uy_le, uy_ge, wy_le, wy_ge;

    // input coordinates narrowed or widened to the working width
    assign qx = COORD_BITS'(i_x);
    assign qy = COORD_BITS'(i_y);

    assign accept   = start && !busy;
    assign room     = (r_count < CNT_W'(MAX_VERTICES));
    assign wr_en    = accept && ((i_mode == MODE_START) || ((i_mode == MODE_APPEND) && room));
    assign wr_addr  = (i_mode == MODE_START) ? '0 : r_count[ADDR_W-1:0];
    assign end_addr = ADDR_W'(r_count - CNT_W'(1));

    assign rd_x = r_rd_data[2*COORD_BITS-1:COORD_BITS];
    assign rd_y = r_rd_data[COORD_BITS-1:0];
    assign dx   = DW'(rd_x) - DW'(r_px);
    assign dy   = DW'(rd_y) - DW'(r_py);

    // memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {qx, qy};
        end
        r_rd_data <= mem[r_rd_addr];
    end

    // sign tests of the edge end offsets
    assign ux_le = r_ux[DW-1] || (r_ux == '0);
    assign ux_ge = !r_ux[DW-1];
    assign wx_le = r_wx[DW-1] || (r_wx == '0);
    assign wx_ge = !r_wx[DW-1];
    assign uy_le = r_uy[DW-1] || (r_uy == '0);
    assign uy_ge = !r_uy[DW-1];
    assign wy_le = r_wy[DW-1] || (r_wy == '0);
    assign wy_ge = !r_wy[DW-1];

    // cross product of the offsets and winding step
    assign cross_prod = (PW+1)'(r_p1) - (PW+1)'(r_p2);
    assign cross_zero = (cross_prod == '0);
    assign cross_neg  = cross_prod[PW];
    assign cross_pos  = !cross_neg && !cross_zero;
    assign edge_stop  = r_e3 && (r_hit || (cross_zero && r_box));
    assign walk_done  = r_e3 && (edge_stop || r_last3);

    always_comb begin
        wind_step = '0;
        if (r_up && cross_pos) begin
            wind_step = WW'(1);
        end else if (r_dn && cross_neg) begin
            wind_step = -WW'(1);
        end
    end

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_issuing  = r_issuing;
        n_rd_addr  = r_rd_addr;
        n_v1       = 1'b0;
        n_e2       = 1'b0;
        n_e3       = 1'b0;
        n_wind     = r_wind;
        n_strobe   = 1'b0;
        n_class    = r_class;
        n_dropped  = r_dropped;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_START: begin
                            n_count    = CNT_W'(1);
                            n_overflow = 1'b0;
                        end
                        MODE_APPEND: begin
                            if (room) begin
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        MODE_CLASSIFY: begin
                            n_dropped = r_overflow;
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_class  = CLASS_OUTSIDE;
                            end else if ((qx == r_last_x) && (qy == r_last_y)) begin
                                n_strobe = 1'b1;
                                n_class  = CLASS_VERTEX;
                            end else if (r_count == CNT_W'(1)) begin
                                n_strobe = 1'b1;
                                n_class  = CLASS_OUTSIDE;
                            end else begin
                                n_state   = S_WALK;
                                n_issuing = 1'b1;
                                n_rd_addr = '0;
                                n_wind    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                // address issue
                if (r_issuing) begin
                    n_rd_addr = r_rd_addr + ADDR_W'(1);
                    if (r_rd_addr == end_addr) begin
                        n_issuing = 1'b0;
                    end
                end
                n_v1   = r_issuing;
                n_e2   = r_v1 && !r_first1;
                n_e3   = r_e2;
                if (r_e3) begin
                    n_wind = r_wind + wind_step;
                end
                // early hit or last edge ends the walk
                if (walk_done) begin
                    n_state   = S_IDLE;
                    n_issuing = 1'b0;
                    n_v1      = 1'b0;
                    n_e2      = 1'b0;
                    n_e3      = 1'b0;
                    n_strobe  = 1'b1;
                    if (edge_stop) begin
                        n_class = r_hit ? CLASS_VERTEX : CLASS_EDGE;
                    end else begin
                        n_class = (n_wind != '0) ? CLASS_INSIDE : CLASS_OUTSIDE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_issuing  <= 1'b0;
            r_rd_addr  <= '0;
            r_v1       <= 1'b0;
            r_e2       <= 1'b0;
            r_e3       <= 1'b0;
            r_wind     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_issuing  <= n_issuing;
            r_rd_addr  <= n_rd_addr;
            r_v1       <= n_v1;
            r_e2       <= n_e2;
            r_e3       <= n_e3;
            r_wind     <= n_wind;
            r_strobe   <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_class   <= n_class;
        r_dropped <= n_dropped;
        if (wr_en) begin
            r_last_x <= qx;
            r_last_y <= qy;
        end
        if (accept && (i_mode == MODE_CLASSIFY)) begin
            r_px <= qx;
            r_py <= qy;
        end
        // read tags follow the address
        r_first1 <= (r_rd_addr == '0);
        r_last1  <= (r_rd_addr == end_addr);
        // offsets of the current and previous vertex from the point
        if (r_v1) begin
            r_wx    <= dx;
            r_wy    <= dy;
            r_ux    <= r_wx;
            r_uy    <= r_wy;
            r_last2 <= r_last1;
        end
        // products and edge flags
        if (r_e2) begin
            r_p1    <= r_ux * r_wy;
            r_p2    <= r_wx * r_uy;
            r_hit   <= ((r_ux == '0) && (r_uy == '0)) || ((r_wx == '0) && (r_wy == '0));
            r_box   <= ((ux_le && wx_ge) || (wx_le && ux_ge)) &&
                       ((uy_le && wy_ge) || (wy_le && uy_ge));
            r_up    <= uy_le && !wy_le;
            r_dn    <= !uy_le && wy_le;
            r_last3 <= r_last2;
        end
    end

    assign busy               = (r_state == S_WALK);
    assign o_strobe           = r_strobe;
    assign o_position_class   = r_class;
    assign o_vertices_dropped = r_dropped;

`ifndef NO_ASSERTIONS
    // results never overlap a running walk
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while walking");

    // every result comes from a query transfer or the end of a walk
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start && !busy && (i_mode == MODE_CLASSIFY)) ||
                      $past(r_state == S_WALK)))
        else $error("result without a query");

    // vertex count never exceeds the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count overflow");

    // pipeline stages only carry edges during a walk
    a_pipe_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e3 || r_e2 || r_v1) |-> (r_state == S_WALK))
        else $error("edge in flight outside walk");
`endif

endmodule

FILE: sim/winding_point_in_polygon_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winding_point_in_polygon_classifier_tb
// Self-checking bench for the point-in-polygon classifier. A directed table
// covers the empty store, single vertices, extreme coordinates, edge and
// vertex hits and a doubly wound outline. Random polygons then follow, with
// queries aimed at vertices, edge midpoints and free points, plus a full
// store that overflows. Random query results are checked against a
// predictor with its own copy of the vertex store; table rows pin theirs.
// ----------------------------------------------------------------------------
module winding_point_in_polygon_classifier_tb;
    import wpip_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int CLK_PERIOD = 2 * CLK_HALF;
    localparam int STORE_SIZE = 1024;
    localparam int DRAIN_CYC  = 1100;
    localparam int MAX_REPORT = 10;

    // mode code the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] pclass;
        logic       dropped;
    } t_verdict;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               pinned;
        logic [1:0]         pclass;
        logic               dropped;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic signed [15:0] i_x;
    logic signed [15:0] i_y;
    logic               o_strobe;
    logic [1:0]         o_position_class;
    logic               o_vertices_dropped;

    // predictor copy of the block state
    longint   poly_x [STORE_SIZE];
    longint   poly_y [STORE_SIZE];
    int       poly_len;
    logic     poly_dropped;

    t_verdict pending_verdicts[$];
    t_row     plan[$];
    int       err_count;
    int       gap_pct;
    bit       pin_on;
    t_verdict pin_verdict;

    winding_point_in_polygon_classifier u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_x                (i_x),
        .i_y                (i_y),
        .o_strobe           (o_strobe),
        .o_position_class   (o_position_class),
        .o_vertices_dropped (o_vertices_dropped)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // safety net against a hung run
    initial begin
        #(CLK_PERIOD * 10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // winding-number classification of one point against the stored outline
    function automatic logic [1:0] locate_point(longint px, longint py);
        longint ax, ay, bx, by, crs;
        int     n;
        int     wind;
        if (poly_len == 0) return CLASS_OUTSIDE;
        n = poly_len - 1;
        if (poly_x[n] == px && poly_y[n] == py) return CLASS_VERTEX;
        wind = 0;
        for (int i = 0; i < n; i++) begin
            ax = poly_x[i];
            ay = poly_y[i];
            bx = poly_x[i + 1];
            by = poly_y[i + 1];
            if ((ax == px && ay == py) || (bx == px && by == py)) return CLASS_VERTEX;
            if ((ax - px) * (by - py) == (bx - px) * (ay - py) &&
                ((ax < bx) ? ax : bx) <= px && px <= ((ax > bx) ? ax : bx) &&
                ((ay < by) ? ay : by) <= py && py <= ((ay > by) ? ay : by))
                return CLASS_EDGE;
            crs = (bx - ax) * (py - ay) - (px - ax) * (by - ay);
            if (ay <= py) begin
                if (by > py && crs > 0) wind++;
            end else begin
                if (by <= py && crs < 0) wind--;
            end
        end
        return (wind != 0) ? CLASS_INSIDE : CLASS_OUTSIDE;
    endfunction

    // update the predictor with one accepted transfer
    task automatic absorb_item(logic [1:0] m, logic signed [15:0] xv, logic signed [15:0] yv);
        t_verdict v;
        case (m)
            MODE_START: begin
                poly_x[0]    = xv;
                poly_y[0]    = yv;
                poly_len     = 1;
                poly_dropped = 1'b0;
            end
            MODE_APPEND: begin
                if (poly_len < STORE_SIZE) begin
                    poly_x[poly_len] = xv;
                    poly_y[poly_len] = yv;
                    poly_len++;
                end else begin
                    poly_dropped = 1'b1;
                end
            end
            MODE_CLASSIFY: begin
                if (pin_on) begin
                    v = pin_verdict;
                end else begin
                    v.pclass  = locate_point(xv, yv);
                    v.dropped = poly_dropped;
                end
                pending_verdicts.push_back(v);
            end
            default: ;
        endcase
    endtask

    // result check, then transfer capture
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (pending_verdicts.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORT)
                        $display("unexpected result: class=%0d dropped=%0b",
                                 o_position_class, o_vertices_dropped);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_position_class !== want.pclass ||
                        o_vertices_dropped !== want.dropped) begin
                        err_count++;
                        if (err_count <= MAX_REPORT)
                            $display("mismatch: expected class=%0d dropped=%0b, got class=%0d dropped=%0b",
                                     want.pclass, want.dropped,
                                     o_position_class, o_vertices_dropped);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                absorb_item(i_mode, i_x, i_y);
        end
    end

    // one transfer, entered and left just after a falling edge
    task automatic send_item(logic [1:0] m, logic signed [15:0] xv, logic signed [15:0] yv,
                             bit pinned, logic [1:0] pc, logic pd);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        pin_on         = pinned;
        pin_verdict    = {pc, pd};
        start  <= 1'b1;
        i_mode <= m;
        i_x    <= xv;
        i_y    <= yv;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender holds off until every query has answered
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_verdicts.size() != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic plan_row(logic [1:0] m, int xv, int yv, bit pinned,
                            logic [1:0] pc, logic pd);
        t_row r;
        r.mode    = m;
        r.x       = xv[15:0];
        r.y       = yv[15:0];
        r.pinned  = pinned;
        r.pclass  = pc;
        r.dropped = pd;
        plan.push_back(r);
    endtask

    // coordinates at a few magnitudes, small ones make hits likely
    function automatic logic signed [15:0] rand_coord(int scale);
        int pick;
        case (scale)
            0: return 16'(int'($urandom_range(16)) - 8);
            1: return 16'(int'($urandom_range(400)) - 200);
            2: return 16'($urandom);
            default: begin
                pick = $urandom_range(6);
                case (pick)
                    0: return -16'sd32768;
                    1: return -16'sd32767;
                    2: return -16'sd1;
                    3: return 16'sd0;
                    4: return 16'sd1;
                    5: return 16'sd32766;
                    default: return 16'sd32767;
                endcase
            end
        endcase
    endfunction

    // full store: closed outline of the whole depth, then dropped appends
    task automatic fill_store();
        logic signed [15:0] fx, fy;
        fx = rand_coord(2);
        fy = rand_coord(2);
        send_item(MODE_START, fx, fy, 0, CLASS_OUTSIDE, 1'b0);
        for (int k = 1; k < STORE_SIZE - 1; k++)
            send_item(MODE_APPEND, rand_coord(2), rand_coord(2), 0, CLASS_OUTSIDE, 1'b0);
        send_item(MODE_APPEND, fx, fy, 0, CLASS_OUTSIDE, 1'b0);
        repeat (2) send_item(MODE_CLASSIFY, rand_coord(2), rand_coord(1), 0, CLASS_OUTSIDE, 1'b0);
        repeat (3) send_item(MODE_APPEND, rand_coord(2), rand_coord(2), 0, CLASS_OUTSIDE, 1'b0);
        repeat (2) send_item(MODE_CLASSIFY, rand_coord(1), rand_coord(2), 0, CLASS_OUTSIDE, 1'b0);
        send_item(MODE_CLASSIFY, fx, fy, 0, CLASS_OUTSIDE, 1'b0);
    endtask

    // random polygons and queries at one sender idle rate
    task automatic run_phase(int pct, int quota, bit with_fill);
        logic signed [15:0] gx [12];
        logic signed [15:0] gy [12];
        logic signed [15:0] qx, qy;
        int sent, kind, nv, scale, nq, pick, k, k2;
        bit filled;
        gap_pct = pct;
        sent    = 0;
        filled  = 0;
        nv      = 0;
        scale   = 0;
        while (sent < quota) begin
            if (with_fill && !filled && sent >= quota / 2) begin
                fill_store();
                filled = 1;
                nv     = 0;
            end
            kind = $urandom_range(99);
            if (kind < 75) begin
                // well-formed outline, mostly closed, then queries
                scale = ($urandom_range(9) < 6) ? $urandom_range(1) : $urandom_range(3);
                nv    = $urandom_range(1, 10);
                for (k = 0; k < nv; k++) begin
                    gx[k] = rand_coord(scale);
                    gy[k] = rand_coord(scale);
                    send_item((k == 0) ? MODE_START : MODE_APPEND, gx[k], gy[k],
                              0, CLASS_OUTSIDE, 1'b0);
                    sent++;
                end
                if (nv > 1 && $urandom_range(99) < 85) begin
                    send_item(MODE_APPEND, gx[0], gy[0], 0, CLASS_OUTSIDE, 1'b0);
                    sent++;
                end
                nq = $urandom_range(1, 5);
                repeat (nq) begin
                    pick = $urandom_range(3);
                    k    = $urandom_range(nv - 1);
                    k2   = (k + 1) % nv;
                    case (pick)
                        0: begin
                            qx = gx[k];
                            qy = gy[k];
                        end
                        1: begin
                            qx = 16'((int'(gx[k]) + int'(gx[k2])) >>> 1);
                            qy = 16'((int'(gy[k]) + int'(gy[k2])) >>> 1);
                        end
                        2: begin
                            qx = rand_coord(scale);
                            qy = rand_coord(scale);
                        end
                        default: begin
                            qx = rand_coord(2);
                            qy = rand_coord(2);
                        end
                    endcase
                    send_item(MODE_CLASSIFY, qx, qy, 0, CLASS_OUTSIDE, 1'b0);
                    sent++;
                end
            end else if (kind < 85) begin
                // stray append or query onto whatever is stored
                send_item(($urandom_range(1) == 0) ? MODE_APPEND : MODE_CLASSIFY,
                          rand_coord(scale), rand_coord(scale), 0, CLASS_OUTSIDE, 1'b0);
                sent++;
            end else if (kind < 92) begin
                // unused mode, ignored by the block
                send_item(MODE_UNUSED, rand_coord(2), rand_coord(2), 0, CLASS_OUTSIDE, 1'b0);
            end else begin
                send_item(MODE_CLASSIFY, rand_coord(3), rand_coord(2), 0, CLASS_OUTSIDE, 1'b0);
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        t_row r;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = MODE_START;
        i_x          = '0;
        i_y          = '0;
        poly_len     = 0;
        poly_dropped = 1'b0;
        err_count    = 0;
        gap_pct      = 0;
        pin_on       = 0;
        pin_verdict  = '0;

        // empty store, unused mode, single vertex
        plan_row(MODE_CLASSIFY, 0, 0, 1, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_UNUSED, 5, 5, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_CLASSIFY, 32767, -32768, 1, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_START, 7, -3, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_CLASSIFY, 7, -3, 1, CLASS_VERTEX, 1'b0);
        plan_row(MODE_CLASSIFY, 8, -3, 1, CLASS_OUTSIDE, 1'b0);
        // full-range square
        plan_row(MODE_START, -32768, -32768, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_APPEND, 32767, -32768, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_APPEND, 32767, 32767, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_APPEND, -32768, 32767, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_APPEND, -32768, -32768, 0, CLASS_OUTSIDE, 1'b0);
        plan_row(MODE_CLASSIFY, 0, 0, 1, CLASS_INSIDE, 1'b0);
        plan_row(MODE_CLASSIFY, 32767, 32767, 1, CLASS_VERTEX, 1'b0);
        plan_row(MODE_CLASSIFY, 0, -32768, 1, CLASS_EDGE, 1'b0);
        plan_row(MODE_CLASSIFY, -32768, 0, 1, CLASS_EDGE, 1'b0);
        // square wound twice, winding two still reads inside
        plan_row(MODE_START, 0, 0, 0, CLASS_OUTSIDE, 1'b0);
        for (int lap = 0; lap < 2; lap++) begin
            plan_row(MODE_APPEND, 10, 0, 0, CLASS_OUTSIDE, 1'b0);
            plan_row(MODE_APPEND, 10, 10, 0, CLASS_OUTSIDE, 1'b0);
            plan_row(MODE_APPEND, 0, 10, 0, CLASS_OUTSIDE, 1'b0);
            plan_row(MODE_APPEND, 0, 0, 0, CLASS_OUTSIDE, 1'b0);
        end
        plan_row(MODE_CLASSIFY, 5, 5, 1, CLASS_INSIDE, 1'b0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[j]) begin
            r = plan[j];
            send_item(r.mode, r.x, r.y, r.pinned, r.pclass, r.dropped);
        end

        run_phase(36, 190, 0);
        hold_until_drained();
        run_phase(69, 190, 0);
        hold_until_drained();
        run_phase(0, 190, 1);

        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
